[rtl/cdeq_pkg.sv]
// package for the circular double-ended queue
// action and status codes, controller command and status structs; no dependencies
`default_nettype none

package cdeq_pkg;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_PEEK_FRONT = 3'd4,
        ACT_PEEK_BACK  = 3'd5
    } cdeq_action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } cdeq_status_t;

    // commands from controller to datapath, already qualified by the request handshake
    typedef struct packed {
        logic wr_front;
        logic wr_back;
        logic rd_front;
        logic rd_back;
        logic pop_front;
        logic pop_back;
    } cdeq_cmd_t;

    // datapath status seen by the controller
    typedef struct packed {
        logic full;
        logic empty;
    } cdeq_stat_t;

endpackage

`default_nettype wire

[rtl/cdeq_req_if.sv]
// request channel of the queue: valid/ready handshake with action and push value
// depends on cdeq_pkg
`default_nettype none

interface cdeq_req_if
    import cdeq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

`default_nettype wire

[rtl/cdeq_rsp_if.sv]
// response channel of the queue: valid/ready handshake with status, data and count
// depends on cdeq_pkg; CNT_W must match the queue's count width
`default_nettype none

interface cdeq_rsp_if
    import cdeq_pkg::*;
#(
    parameter int CNT_W = 5
);
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         element_count;
    logic                     is_empty;

    modport source (output valid, output status, output read_value, output element_count,
                    output is_empty, input ready);
    modport sink   (input valid, input status, input read_value, input element_count,
                    input is_empty, output ready);
endinterface

`default_nettype wire

[rtl/cdeq_ctrl.sv]
// controller of the queue: handshake state, action decode and response status
// depends on cdeq_pkg
`default_nettype none

module cdeq_ctrl
    import cdeq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic [ACTION_W-1:0] action,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output logic [STATUS_W-1:0]      status,
    output logic                     show_rd,
    output cdeq_cmd_t                cmd,
    input  wire cdeq_stat_t          stat
);

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } state_t;

    state_t       state_reg, state_next;
    cdeq_status_t status_reg, status_next;
    logic         show_rd_reg, show_rd_next;
    logic         accept;

    // a new request may enter while the previous response leaves
    assign req_ready = (state_reg == S_IDLE) || rsp_ready;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        cmd          = '0;
        status_next  = ST_OK;
        show_rd_next = 1'b0;
        case (cdeq_action_t'(action))
            ACT_PUSH_FRONT:
            begin
                if (stat.full)
                    status_next = ST_FULL;
                else
                    cmd.wr_front = accept;
            end
            ACT_PUSH_BACK:
            begin
                if (stat.full)
                    status_next = ST_FULL;
                else
                    cmd.wr_back = accept;
            end
            ACT_POP_FRONT:
            begin
                if (stat.empty)
                    status_next = ST_EMPTY;
                else
                begin
                    cmd.rd_front  = accept;
                    cmd.pop_front = accept;
                    show_rd_next  = 1'b1;
                end
            end
            ACT_POP_BACK:
            begin
                if (stat.empty)
                    status_next = ST_EMPTY;
                else
                begin
                    cmd.rd_back  = accept;
                    cmd.pop_back = accept;
                    show_rd_next = 1'b1;
                end
            end
            ACT_PEEK_FRONT:
            begin
                if (stat.empty)
                    status_next = ST_EMPTY;
                else
                begin
                    cmd.rd_front = accept;
                    show_rd_next = 1'b1;
                end
            end
            ACT_PEEK_BACK:
            begin
                if (stat.empty)
                    status_next = ST_EMPTY;
                else
                begin
                    cmd.rd_back  = accept;
                    show_rd_next = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (accept)
                    state_next = S_HOLD;
                else if (rsp_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            status_reg  <= ST_OK;
            show_rd_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                status_reg  <= status_next;
                show_rd_reg <= show_rd_next;
            end
        end
    end

    assign rsp_valid = (state_reg == S_HOLD);
    assign status    = status_reg;
    assign show_rd   = show_rd_reg;

endmodule

`default_nettype wire

[rtl/cdeq_dpath.sv]
// datapath of the queue: slot memory, front index and element count
// depends on cdeq_pkg
`default_nettype none

module cdeq_dpath
    import cdeq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cdeq_cmd_t                cmd,
    input  wire logic                     show_rd,
    input  wire logic signed [DATA_W-1:0] push_value,
    output cdeq_stat_t                    stat,
    output logic signed [DATA_W-1:0]      read_value,
    output logic [CNT_W-1:0]              element_count,
    output logic                          is_empty
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [IDX_W-1:0]  front_dec, front_inc;
    logic [SUM_W-1:0]  back_sum, last_sum, back_wrap, last_wrap;
    logic [IDX_W-1:0]  wr_addr, rd_addr;

    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;

    // slot one past the back and the back slot itself, wrapped once
    assign back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign last_sum  = back_sum - 1'b1;
    assign back_wrap = (back_sum >= CAP_SUM) ? back_sum - CAP_SUM : back_sum;
    assign last_wrap = (last_sum >= CAP_SUM) ? last_sum - CAP_SUM : last_sum;

    assign wr_addr = cmd.wr_front ? front_dec : back_wrap[IDX_W-1:0];
    assign rd_addr = cmd.rd_front ? front_reg : last_wrap[IDX_W-1:0];

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        if (cmd.wr_front)
            front_next = front_dec;
        else if (cmd.pop_front)
            front_next = front_inc;
        if (cmd.wr_front || cmd.wr_back)
            count_next = count_reg + 1'b1;
        else if (cmd.pop_front || cmd.pop_back)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_front || cmd.wr_back)
            mem[wr_addr] <= push_value;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_front || cmd.rd_back)
            rdata_reg <= mem[rd_addr];
    end

    assign stat.full     = (count_reg == CAP_CNT);
    assign stat.empty    = (count_reg == '0);
    assign read_value    = show_rd ? $signed(rdata_reg) : '0;
    assign element_count = count_reg;
    assign is_empty      = (count_reg == '0);

endmodule

`default_nettype wire

[rtl/circular_double_ended_queue.sv]
// double-ended queue of signed 32-bit values in a circular slot memory
// response: valid in the cycle after the request is taken, from registers
// throughput: one request per cycle while responses are taken; a stalled response
// holds the request channel until it leaves
// reset: front index, count and handshake state clear; slot memory is not cleared
// depends on cdeq_pkg, cdeq_req_if, cdeq_rsp_if, cdeq_ctrl, cdeq_dpath
`default_nettype none

module circular_double_ended_queue
    import cdeq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cdeq_req_if.sink    req_in,
    cdeq_rsp_if.source  rsp_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cdeq_cmd_t  cmd;
    cdeq_stat_t stat;
    logic       show_rd;
    logic [CNT_W-1:0] count;

    cdeq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_in.valid),
        .req_ready (req_in.ready),
        .action    (req_in.action),
        .rsp_valid (rsp_out.valid),
        .rsp_ready (rsp_out.ready),
        .status    (rsp_out.status),
        .show_rd   (show_rd),
        .cmd       (cmd),
        .stat      (stat)
    );

    cdeq_dpath #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .show_rd       (show_rd),
        .push_value    (req_in.push_value),
        .stat          (stat),
        .read_value    (rsp_out.read_value),
        .element_count (count),
        .is_empty      (rsp_out.is_empty)
    );

    assign rsp_out.element_count = count;

endmodule

`default_nettype wire

[rtl/cdeq_check.sv]
// port-level checks for the queue, attached to the top level by bind
// depends on cdeq_pkg
`default_nettype none

module cdeq_check
    import cdeq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [DATA_W-1:0]   read_value,
    input wire logic [CNT_W-1:0]    element_count,
    input wire logic                is_empty
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // empty flag tracks the count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (element_count == '0)))
        else $error("is_empty disagrees with element_count");

    // a refused push only happens at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_FULL) |-> (element_count == CAP_CNT))
        else $error("full status below capacity");

    // a refused pop or peek leaves an empty queue and no data
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_EMPTY) |-> (is_empty && read_value == '0))
        else $error("empty status with data or elements");

    // a stalled response holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(status) && $stable(read_value) && $stable(element_count)))
        else $error("response changed while stalled");

endmodule

bind circular_double_ended_queue cdeq_check #(
    .CAPACITY (CAPACITY)
) u_cdeq_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp_out.valid),
    .rsp_ready     (rsp_out.ready),
    .status        (rsp_out.status),
    .read_value    (rsp_out.read_value),
    .element_count (rsp_out.element_count),
    .is_empty      (rsp_out.is_empty)
);

`default_nettype wire
